@@ sv/vector3_normalize_macros.svh @@
// Assertion helpers for the vector normalizer.
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define VN_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector3_normalize: check failed");

// Implication over a fixed number of cycles.
`define VN_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error("vector3_normalize: latency check failed");

`endif

@@ sv/vn_pkg.sv @@
package vn_pkg;

  localparam int unsigned CompW    = 32;
  localparam int unsigned ProdW    = 2 * CompW;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned SqrtN    = CompW;
  localparam int unsigned SqrtRemW = CompW + 2;
  localparam int unsigned FracW    = 16;
  localparam int unsigned QuotW    = FracW + 1;
  localparam int unsigned DivN     = QuotW;
  // input reg, square, sum, sqrt steps, divide steps, output reg
  localparam int unsigned Latency  = 3 + SqrtN + DivN + 1;

  typedef logic [CompW-1:0] comp_t;

  typedef struct packed {
    comp_t mag;
    logic  neg;
  } lane_t;

  typedef lane_t [NumLanes-1:0] lanes_t;

endpackage

@@ sv/vector3_normalize.sv @@
// vector3_normalize: input, square, sum, root and divider stages lead to out_valid.
// Throughput one vector per cycle; busy is always low and every cycle may carry a start.
// The 32 one-bit square-root stages and the 17 one-bit divider stages set the latency.
// The receiver cannot stall: each result shows for exactly one cycle with out_valid.
// rst_n is synchronous, active low, and clears only the valid bits of the pipeline.
module vector3_normalize (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_vec_x,
  input  logic signed [31:0]  in_vec_y,
  input  logic signed [31:0]  in_vec_z,
  output logic                out_valid,
  output logic signed [31:0]  out_unit_x,
  output logic signed [31:0]  out_unit_y,
  output logic signed [31:0]  out_unit_z,
  output logic [31:0]         out_length,
  output logic                out_zero_vector
);

  // Pipeline never blocks, so an item may enter every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------
  // Stage 1: absolute values and signs
  // ---------------------------------------------------------------
  logic           v1_r;
  vn_pkg::lanes_t lanes1_r;
  vn_pkg::lanes_t lanes1_nxt;
  vn_pkg::comp_t  raw_in [vn_pkg::NumLanes];

  assign raw_in[0] = in_vec_x;
  assign raw_in[1] = in_vec_y;
  assign raw_in[2] = in_vec_z;

  always_comb begin
    for (int l = 0; l < vn_pkg::NumLanes; l++) begin
      lanes1_nxt[l].neg = raw_in[l][vn_pkg::CompW-1];
      // two's complement negate; the most negative value maps to 2^31 unsigned
      lanes1_nxt[l].mag = raw_in[l][vn_pkg::CompW-1] ? (~raw_in[l] + 1'b1) : raw_in[l];
    end
  end

  always_ff @(posedge clk) begin
    lanes1_r <= lanes1_nxt;
  end

  // ---------------------------------------------------------------
  // Stage 2: squares, one 32x32 multiplier per lane
  // ---------------------------------------------------------------
  logic                      v2_r;
  vn_pkg::lanes_t            lanes2_r;
  logic [vn_pkg::ProdW-1:0]  sq2_r [vn_pkg::NumLanes];

  always_ff @(posedge clk) begin
    lanes2_r <= lanes1_r;
    for (int l = 0; l < vn_pkg::NumLanes; l++) begin
      sq2_r[l] <= vn_pkg::ProdW'(lanes1_r[l].mag) * vn_pkg::ProdW'(lanes1_r[l].mag);
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: sum of squares (Q32.32, below 2^64, no overflow)
  // ---------------------------------------------------------------
  logic                      v3_r;
  vn_pkg::lanes_t            lanes3_r;
  logic [vn_pkg::ProdW-1:0]  sum3_r;

  always_ff @(posedge clk) begin
    lanes3_r <= lanes2_r;
    sum3_r   <= sq2_r[0] + sq2_r[1] + sq2_r[2];
  end

  // ---------------------------------------------------------------
  // Square root: digit-by-digit, one root bit per stage, MSB first.
  // Each stage pulls two radicand bits into the partial remainder and
  // tries to subtract (4*root + 1).
  // ---------------------------------------------------------------
  logic                         sq_v_r    [vn_pkg::SqrtN];
  logic [vn_pkg::ProdW-1:0]     sq_rad_r  [vn_pkg::SqrtN];
  logic [vn_pkg::SqrtRemW-1:0]  sq_rem_r  [vn_pkg::SqrtN];
  vn_pkg::comp_t                sq_root_r [vn_pkg::SqrtN];
  vn_pkg::lanes_t               sq_lanes_r[vn_pkg::SqrtN];

  for (genvar k = 0; k < vn_pkg::SqrtN; k++) begin : g_sqrt
    logic [vn_pkg::ProdW-1:0]     rad_in;
    logic [vn_pkg::SqrtRemW-1:0]  rem_in;
    vn_pkg::comp_t                root_in;
    vn_pkg::lanes_t               lanes_in;
    logic [vn_pkg::SqrtRemW-1:0]  rem_sh;
    logic [vn_pkg::SqrtRemW-1:0]  trial;
    logic                         ge;

    if (k == 0) begin : g_first
      assign rad_in   = sum3_r;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign lanes_in = lanes3_r;
    end else begin : g_rest
      assign rad_in   = sq_rad_r[k-1];
      assign rem_in   = sq_rem_r[k-1];
      assign root_in  = sq_root_r[k-1];
      assign lanes_in = sq_lanes_r[k-1];
    end

    // partial remainder stays below 2^32 before the shift
    assign rem_sh = {rem_in[vn_pkg::CompW-1:0], rad_in[vn_pkg::ProdW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      sq_rad_r[k]   <= {rad_in[vn_pkg::ProdW-3:0], 2'b00};
      sq_rem_r[k]   <= ge ? (rem_sh - trial) : rem_sh;
      sq_root_r[k]  <= {root_in[vn_pkg::CompW-2:0], ge};
      sq_lanes_r[k] <= lanes_in;
    end
  end

  vn_pkg::comp_t len_w;
  assign len_w = sq_root_r[vn_pkg::SqrtN-1];

  // ---------------------------------------------------------------
  // Division: (mag << 16) / len, three lanes sharing the divisor.
  // The quotient is at most 65536, so the top numerator bits mag[31:1]
  // are already below len and seed the remainder; 17 steps remain.
  // ---------------------------------------------------------------
  logic                        dv_v_r    [vn_pkg::DivN];
  vn_pkg::comp_t               dv_len_r  [vn_pkg::DivN];
  logic                        dv_zero_r [vn_pkg::DivN];
  logic [vn_pkg::NumLanes-1:0] dv_neg_r  [vn_pkg::DivN];
  vn_pkg::comp_t               dv_rem_r  [vn_pkg::DivN][vn_pkg::NumLanes];
  logic [vn_pkg::QuotW-1:0]    dv_q_r    [vn_pkg::DivN][vn_pkg::NumLanes];

  for (genvar j = 0; j < vn_pkg::DivN; j++) begin : g_div
    vn_pkg::comp_t               len_in;
    logic                        zero_in;
    logic [vn_pkg::NumLanes-1:0] neg_in;
    vn_pkg::comp_t               rem_in [vn_pkg::NumLanes];
    logic [vn_pkg::QuotW-1:0]    q_in   [vn_pkg::NumLanes];
    logic [vn_pkg::NumLanes-1:0] nbit;

    if (j == 0) begin : g_first
      assign len_in  = len_w;
      assign zero_in = (len_w == '0);
      for (genvar l = 0; l < vn_pkg::NumLanes; l++) begin : g_lane
        assign neg_in[l] = sq_lanes_r[vn_pkg::SqrtN-1][l].neg;
        assign rem_in[l] = {1'b0, sq_lanes_r[vn_pkg::SqrtN-1][l].mag[vn_pkg::CompW-1:1]};
        assign q_in[l]   = '0;
        assign nbit[l]   = sq_lanes_r[vn_pkg::SqrtN-1][l].mag[0];
      end
    end else begin : g_rest
      assign len_in  = dv_len_r[j-1];
      assign zero_in = dv_zero_r[j-1];
      assign neg_in  = dv_neg_r[j-1];
      for (genvar l = 0; l < vn_pkg::NumLanes; l++) begin : g_lane
        assign rem_in[l] = dv_rem_r[j-1][l];
        assign q_in[l]   = dv_q_r[j-1][l];
        assign nbit[l]   = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      dv_len_r[j]  <= len_in;
      dv_zero_r[j] <= zero_in;
      dv_neg_r[j]  <= neg_in;
      for (int l = 0; l < vn_pkg::NumLanes; l++) begin
        if ({rem_in[l], nbit[l]} >= {1'b0, len_in}) begin
          dv_rem_r[j][l] <= vn_pkg::CompW'({rem_in[l], nbit[l]} - {1'b0, len_in});
          dv_q_r[j][l]   <= {q_in[l][vn_pkg::QuotW-2:0], 1'b1};
        end else begin
          // shifted remainder is below len, so it fits the lane width
          dv_rem_r[j][l] <= {rem_in[l][vn_pkg::CompW-2:0], nbit[l]};
          dv_q_r[j][l]   <= {q_in[l][vn_pkg::QuotW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Output register: sign restore, zero-vector pass-through
  // ---------------------------------------------------------------
  logic          out_valid_r;
  vn_pkg::comp_t unit_nxt [vn_pkg::NumLanes];
  vn_pkg::comp_t unit_r   [vn_pkg::NumLanes];
  vn_pkg::comp_t len_r;
  logic          zero_r;

  always_comb begin
    for (int l = 0; l < vn_pkg::NumLanes; l++) begin
      if (dv_zero_r[vn_pkg::DivN-1]) begin
        // zero vector: inputs were all zero, passed as is
        unit_nxt[l] = '0;
      end else if (dv_neg_r[vn_pkg::DivN-1][l]) begin
        unit_nxt[l] = '0 - vn_pkg::CompW'(dv_q_r[vn_pkg::DivN-1][l]);
      end else begin
        unit_nxt[l] = vn_pkg::CompW'(dv_q_r[vn_pkg::DivN-1][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    len_r  <= dv_len_r[vn_pkg::DivN-1];
    zero_r <= dv_zero_r[vn_pkg::DivN-1];
  end

  // valid bits travel with the data and are the only reset state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      sq_v_r      <= '{default: 1'b0};
      dv_v_r      <= '{default: 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      v1_r      <= accept;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      sq_v_r[0] <= v3_r;
      for (int k = 1; k < vn_pkg::SqrtN; k++) begin
        sq_v_r[k] <= sq_v_r[k-1];
      end
      dv_v_r[0] <= sq_v_r[vn_pkg::SqrtN-1];
      for (int j = 1; j < vn_pkg::DivN; j++) begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
      out_valid_r <= dv_v_r[vn_pkg::DivN-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_unit_x      = unit_r[0];
  assign out_unit_y      = unit_r[1];
  assign out_unit_z      = unit_r[2];
  assign out_length      = len_r;
  assign out_zero_vector = zero_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  logic [vn_pkg::NumLanes-1:0] unit_ok;

  always_comb begin
    for (int l = 0; l < vn_pkg::NumLanes; l++) begin
      unit_ok[l] = ($signed(unit_r[l]) <= 65536) && ($signed(unit_r[l]) >= -65536);
    end
  end

`include "vector3_normalize_macros.svh"

  `VN_ASSERT_DELAY(a_latency, accept, vn_pkg::Latency, out_valid)
  `VN_ASSERT_IMPLY(a_zero_flag, out_valid, out_zero_vector == (out_length == '0))
  `VN_ASSERT_IMPLY(a_zero_units, out_valid && out_zero_vector, (unit_r[0] | unit_r[1] | unit_r[2]) == '0)
  `VN_ASSERT_IMPLY(a_unit_range, out_valid, &unit_ok)

endmodule

@@ test/tb_vector3_normalize.sv @@
`default_nettype none

module tb_vector3_normalize;
  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth from the accepting edge to the strobe, plus margin.
  localparam int unsigned DrainCycles = vn_pkg::Latency + 20;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned NumRandom   = 1000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
    logic [31:0]        len;
    logic               zero;
  } unit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_vec_x = '0;
  logic signed [31:0] in_vec_y = '0;
  logic signed [31:0] in_vec_z = '0;
  logic out_valid;
  logic signed [31:0] out_unit_x;
  logic signed [31:0] out_unit_y;
  logic signed [31:0] out_unit_z;
  logic [31:0] out_length;
  logic out_zero_vector;

  vector3_normalize dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .out_valid(out_valid), .out_unit_x(out_unit_x), .out_unit_y(out_unit_y),
    .out_unit_z(out_unit_z), .out_length(out_length),
    .out_zero_vector(out_zero_vector)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  vec_t  pending_vecs[$];   // items waiting for the driver
  unit_t expected_units[$]; // predictions awaiting a strobe
  int    error_count = 0;
  int    idle_pct = 0;      // sender idle chance, percent
  int unsigned cycle_count = 0;

  // Bitwise floor square root over 64 bits.
  function automatic logic [31:0] floor_sqrt(logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  function automatic unit_t normalize(vec_t v);
    logic [63:0] mag[3];
    logic        neg[3];
    logic [31:0] comp[3];
    logic [63:0] sum;
    logic [63:0] q;
    logic [31:0] lanes[3];
    unit_t r;
    comp[0] = v.x; comp[1] = v.y; comp[2] = v.z;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i][31];
      // Two's complement magnitude; -2^31 comes out as 2^31.
      mag[i] = neg[i] ? {32'd0, (~comp[i]) + 32'd1} : {32'd0, comp[i]};
      if (neg[i] && mag[i] == 0) mag[i] = 64'h8000_0000;
      sum = sum + mag[i] * mag[i];
    end
    r.len = floor_sqrt(sum);
    if (r.len == 0) begin
      // Zero vector passes through unchanged.
      r.ux = v.x; r.uy = v.y; r.uz = v.z;
      r.zero = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] << 16) / {32'd0, r.len};
        lanes[i] = neg[i] ? (32'd0 - q[31:0]) : q[31:0];
      end
      r.ux = lanes[0]; r.uy = lanes[1]; r.uz = lanes[2];
      r.zero = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // Driver: one item per accepted start, random gaps per idle_pct.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (start && !busy) begin
        expected_units.push_back(normalize('{in_vec_x, in_vec_y, in_vec_z}));
      end
      if (start && busy) begin
        // hold the item until taken
      end else if (pending_vecs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        vec_t v;
        v = pending_vecs.pop_front();
        start <= 1'b1;
        in_vec_x <= v.x; in_vec_y <= v.y; in_vec_z <= v.z;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_units.size() == 0) begin
        report_mismatch("unexpected result", out_length, 32'd0);
      end else begin
        unit_t e;
        e = expected_units.pop_front();
        if (out_unit_x !== e.ux) report_mismatch("unit_x", out_unit_x, e.ux);
        if (out_unit_y !== e.uy) report_mismatch("unit_y", out_unit_y, e.uy);
        if (out_unit_z !== e.uz) report_mismatch("unit_z", out_unit_z, e.uz);
        if (out_length !== e.len) report_mismatch("length", out_length, e.len);
        if (out_zero_vector !== e.zero)
          report_mismatch("zero_vector", {31'd0, out_zero_vector}, {31'd0, e.zero});
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(131072) - 65536; // near unit range
      3: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_vecs.size() > 0 || start || expected_units.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    vec_t v;
    // Directed: zero vector, most negative and most positive, single axis, small, mixed and 3-4-5 vectors.
    pending_vecs.push_back('{32'sd0, 32'sd0, 32'sd0});
    pending_vecs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_vecs.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    pending_vecs.push_back('{32'h8000_0000, 32'sd0, 32'sd0});
    pending_vecs.push_back('{32'sd0, 32'h7fff_ffff, 32'sd0});
    pending_vecs.push_back('{32'sd0, 32'sd0, -32'sd65536});
    pending_vecs.push_back('{32'sd1, 32'sd0, 32'sd0});
    pending_vecs.push_back('{32'sd0, -32'sd1, 32'sd0});
    pending_vecs.push_back('{32'sd1, 32'sd1, 32'sd1});
    pending_vecs.push_back('{-32'sd1, -32'sd1, -32'sd1});
    pending_vecs.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'sd1});
    pending_vecs.push_back('{32'sd196608, 32'sd262144, 32'sd0});
    pending_vecs.push_back('{32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa});
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();
    // Random phases: no idling, heavy idling, moderate idling.
    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 0 : (p == 1) ? 85 : 30;
      for (int i = 0; i < NumRandom / 3; i++) begin
        v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp();
        pending_vecs.push_back(v);
      end
      wait_drained();
    end
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
